@@ rtl/sle_pkg.sv @@
// Shared types and constants for the sequential list engine.
// Holds request/status codes, transaction structs, walk flags and the sequencer state type.
// No dependencies.
`default_nettype none

package sle_pkg;

  localparam int REQ_W  = 3;
  localparam int LEN_W  = 7;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_SEARCH = 3'd2,
    REQ_READ   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [LEN_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         found_position;
    logic signed [WORD_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic at_lim;
    logic eq;
  } walk_flags_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_DRAIN,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_DEL_DRAIN,
    S_RD,
    S_RD_DATA,
    S_SRCH,
    S_SRCH_END,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/sle_walk.sv @@
// Shared walk unit: steps the list pointer, tests for the end of the walk
// and compares a stored word against the key. Depends on sle_pkg.
`default_nettype none

module sle_walk import sle_pkg::*; #(
  parameter int AW = 6
) (
  input  wire logic [AW-1:0]     ptr,
  input  wire logic [AW-1:0]     lim,
  input  wire logic              down,
  input  wire logic [WORD_W-1:0] key,
  input  wire logic [WORD_W-1:0] word,
  output logic      [AW-1:0]     nxt,
  output walk_flags_t            flags
);

  assign nxt          = down ? (ptr - AW'(1)) : (ptr + AW'(1));
  assign flags.at_lim = (ptr == lim);
  assign flags.eq     = (key == word);

endmodule

`default_nettype wire

@@ rtl/sequential_list_engine.sv @@
// Sequential list engine: ordered list of signed words in one RAM.
// Depends on sle_pkg, sle_ram and sle_walk.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one request per
//   transaction: insert, delete, search, read or clear, with a one-based
//   position and a word. Result channel (out_valid/out_stall/out_data)
//   returns one result per request, or one per match for a search, the last
//   one flagged by out_data.last. Every result carries the list length.
//   One request is worked at a time; the walk over the RAM (one read and
//   one write port) steps one entry per cycle while it is not held. in_stall
//   is low only while the sequencer is idle, so a new request is taken
//   while the previous result still sits in the output register.
//   A stalled receiver freezes the output register; a search scan waits on
//   it only when a second match must be handed over, and every request waits on it to hand over its final result.
//   Reset empties the list; RAM contents are never cleared, only entries
//   below the length are ever read.
`default_nettype none

module sequential_list_engine import sle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

  state_t state_r, state_nxt;

  // latched request
  logic [REQ_W-1:0]         req_r, req_nxt;
  logic [LEN_W-1:0]         pos_r, pos_nxt;
  logic signed [WORD_W-1:0] val_r, val_nxt;

  logic [LEN_W-1:0] count_r, count_nxt;

  // walk pointer and pending RAM write
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] lim_r, lim_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_cap_r, pend_cap_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          first_r, first_nxt;

  // search bookkeeping
  logic             issue_done_r, issue_done_nxt;
  logic             chk_r, chk_nxt;
  logic [LEN_W-1:0] chk_pos_r, chk_pos_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [LEN_W-1:0] hold_pos_r, hold_pos_nxt;

  // staged result
  logic [STAT_W-1:0]        res_status_r, res_status_nxt;
  logic [LEN_W-1:0]         res_pos_r, res_pos_nxt;
  logic signed [WORD_W-1:0] res_val_r, res_val_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [AW-1:0] walk_nxt;
  walk_flags_t   walk_flags;
  logic          walk_down;

  logic             out_free;
  logic             out_load;
  out_item_t        out_load_data;
  logic [LEN_W-1:0] pm1;
  logic [LEN_W-1:0] cm1;
  logic             ins_full;
  logic             ins_bad;
  logic             pos_bad;
  logic             match;
  logic             freeze;

  sle_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sle_walk #(
    .AW(AW)
  ) u_walk (
    .ptr  (ptr_r),
    .lim  (lim_r),
    .down (walk_down),
    .key  (val_r),
    .word (ram_rdata),
    .nxt  (walk_nxt),
    .flags(walk_flags)
  );

  assign walk_down = (state_r == S_INS_SHIFT);
  assign out_free  = !out_valid_r || !out_stall;
  assign pm1       = pos_r - LEN_W'(1);
  assign cm1       = count_r - LEN_W'(1);
  assign ins_full  = (count_r >= CAP_L);
  assign ins_bad   = (pos_r == '0) || (pos_r > (count_r + LEN_W'(1)));
  assign pos_bad   = (pos_r == '0) || (pos_r > count_r);
  assign match     = chk_r && walk_flags.eq;
  // hold the scan when a second match must go out and the receiver stalls
  assign freeze    = match && hold_v_r && !out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (req_r)
          REQ_INSERT: begin
            if (ins_full || ins_bad)            state_nxt = S_EMIT;
            else if (pos_r == count_r + LEN_W'(1)) state_nxt = S_INS_PUT;
            else                                state_nxt = S_INS_SHIFT;
          end
          REQ_DELETE: state_nxt = pos_bad ? S_EMIT : S_DEL_SHIFT;
          REQ_SEARCH: state_nxt = (count_r == '0) ? S_EMIT : S_SRCH;
          REQ_READ:   state_nxt = pos_bad ? S_EMIT : S_RD;
          default:    state_nxt = S_EMIT;
        endcase
      end
      S_INS_SHIFT: begin
        if (walk_flags.at_lim) state_nxt = S_INS_DRAIN;
      end
      S_INS_DRAIN: state_nxt = S_INS_PUT;
      S_INS_PUT:   state_nxt = S_EMIT;
      S_DEL_SHIFT: begin
        if (walk_flags.at_lim) state_nxt = S_DEL_DRAIN;
      end
      S_DEL_DRAIN: state_nxt = S_EMIT;
      S_RD:        state_nxt = S_RD_DATA;
      S_RD_DATA:   state_nxt = S_EMIT;
      S_SRCH: begin
        if (issue_done_r && !chk_r) state_nxt = S_SRCH_END;
      end
      S_SRCH_END:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    req_nxt        = req_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    lim_nxt        = lim_r;
    pend_nxt       = 1'b0;
    pend_cap_nxt   = pend_cap_r;
    pend_addr_nxt  = pend_addr_r;
    first_nxt      = first_r;
    issue_done_nxt = issue_done_r;
    chk_nxt        = chk_r;
    chk_pos_nxt    = chk_pos_r;
    hold_v_nxt     = hold_v_r;
    hold_pos_nxt   = hold_pos_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_val_nxt    = res_val_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r;
    out_load       = 1'b0;
    out_load_data  = '0;

    // retire the read issued last cycle: capture the removed word or move it
    if (pend_r) begin
      if (pend_cap_r) res_val_nxt = ram_rdata;
      else            ram_we      = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data.req_type;
          pos_nxt = in_data.position;
          val_nxt = in_data.value;
        end
      end
      S_DECODE: begin
        res_status_nxt = ST_OK;
        res_pos_nxt    = '0;
        res_val_nxt    = '0;
        unique case (req_r)
          REQ_INSERT: begin
            if (ins_full)     res_status_nxt = ST_FULL;
            else if (ins_bad) res_status_nxt = ST_BADPOS;
            else begin
              ptr_nxt = cm1[AW-1:0];
              lim_nxt = pm1[AW-1:0];
            end
          end
          REQ_DELETE: begin
            if (pos_bad) res_status_nxt = ST_BADPOS;
            else begin
              ptr_nxt   = pm1[AW-1:0];
              lim_nxt   = cm1[AW-1:0];
              first_nxt = 1'b1;
            end
          end
          REQ_SEARCH: begin
            if (count_r == '0) res_status_nxt = ST_NOTFOUND;
            else begin
              ptr_nxt        = '0;
              lim_nxt        = cm1[AW-1:0];
              issue_done_nxt = 1'b0;
              chk_nxt        = 1'b0;
              hold_v_nxt     = 1'b0;
            end
          end
          REQ_READ: begin
            if (pos_bad) res_status_nxt = ST_BADPOS;
            else         ptr_nxt        = pm1[AW-1:0];
          end
          REQ_CLEAR: count_nxt = '0;
          default: ;
        endcase
      end
      S_INS_SHIFT: begin
        // read entry ptr, write it one place up next cycle
        ram_re        = 1'b1;
        pend_nxt      = 1'b1;
        pend_cap_nxt  = 1'b0;
        pend_addr_nxt = ptr_r + AW'(1);
        if (!walk_flags.at_lim) ptr_nxt = walk_nxt;
      end
      S_INS_DRAIN: ;
      S_INS_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = pm1[AW-1:0];
        ram_wdata      = val_r;
        count_nxt      = count_r + LEN_W'(1);
        res_status_nxt = ST_OK;
        res_pos_nxt    = pos_r;
        res_val_nxt    = val_r;
      end
      S_DEL_SHIFT: begin
        // first read fetches the removed word, later ones move down a place
        ram_re        = 1'b1;
        pend_nxt      = 1'b1;
        pend_cap_nxt  = first_r;
        first_nxt     = 1'b0;
        pend_addr_nxt = ptr_r - AW'(1);
        if (!walk_flags.at_lim) ptr_nxt = walk_nxt;
      end
      S_DEL_DRAIN: begin
        count_nxt      = cm1;
        res_status_nxt = ST_OK;
        res_pos_nxt    = pos_r;
      end
      S_RD: ram_re = 1'b1;
      S_RD_DATA: begin
        res_status_nxt = ST_OK;
        res_pos_nxt    = pos_r;
        res_val_nxt    = ram_rdata;
      end
      S_SRCH: begin
        if (!freeze) begin
          ram_re      = !issue_done_r;
          chk_nxt     = !issue_done_r;
          chk_pos_nxt = LEN_W'(ptr_r) + LEN_W'(1);
          if (!issue_done_r) begin
            if (walk_flags.at_lim) issue_done_nxt = 1'b1;
            else                   ptr_nxt        = walk_nxt;
          end
          // a match is kept back until the next one so the final one can carry last
          if (match) begin
            if (hold_v_r) begin
              out_load                     = 1'b1;
              out_load_data.status         = ST_OK;
              out_load_data.found_position = hold_pos_r;
              out_load_data.read_value     = val_r;
              out_load_data.list_length    = count_r;
              out_load_data.last           = 1'b0;
            end
            hold_v_nxt   = 1'b1;
            hold_pos_nxt = chk_pos_r;
          end
        end
      end
      S_SRCH_END: begin
        hold_v_nxt = 1'b0;
        if (hold_v_r) begin
          res_status_nxt = ST_OK;
          res_pos_nxt    = hold_pos_r;
          res_val_nxt    = val_r;
        end else begin
          res_status_nxt = ST_NOTFOUND;
          res_pos_nxt    = '0;
          res_val_nxt    = '0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load                     = 1'b1;
          out_load_data.status         = res_status_r;
          out_load_data.found_position = res_pos_r;
          out_load_data.read_value     = res_val_r;
          out_load_data.list_length    = count_r;
          out_load_data.last           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = out_load_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      first_r      <= 1'b0;
      issue_done_r <= 1'b0;
      chk_r        <= 1'b0;
      hold_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      first_r      <= first_nxt;
      issue_done_r <= issue_done_nxt;
      chk_r        <= chk_nxt;
      hold_v_r     <= hold_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    lim_r        <= lim_nxt;
    pend_cap_r   <= pend_cap_nxt;
    pend_addr_r  <= pend_addr_nxt;
    chk_pos_r    <= chk_pos_nxt;
    hold_pos_r   <= hold_pos_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_val_r    <= res_val_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/sle_checker.sv @@
// Port-level checks for the sequential list engine, bound to the top level.
// Depends on sle_pkg and sequential_list_engine.
`default_nettype none

module sle_checker import sle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  // one request at a time: busy right after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in progress");

  // only search matches may be followed by more results
  a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_OK)
    else $error("non-final result with failing status");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.list_length <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.found_position == '0 && out_data.read_value == '0)
    else $error("failing result carries position or value");

endmodule

bind sequential_list_engine sle_checker #(
  .CAPACITY(CAPACITY)
) u_sle_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

@@ bench/sle_list_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the sequential list engine: mirrors the list on every
// accepted request transaction and compares each accepted result with the oldest prediction.
// Depends on sle_pkg.

module sle_list_checker import sle_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  output int               fail_count,
  output int               pending_cnt,
  output logic [LEN_W-1:0] tracked_len
);

  logic [WORD_W-1:0] list_words [CAPACITY];
  int                list_len;
  out_item_t         awaited_results [$];

  // Queue one predicted result; the length field is the length after the request.
  task automatic push_result(input logic [STAT_W-1:0] status, input int pos,
                             input logic [WORD_W-1:0] word, input logic last);
    out_item_t r;
    r.status         = status;
    r.found_position = LEN_W'(pos);
    r.read_value     = word;
    r.list_length    = LEN_W'(list_len);
    r.last           = last;
    awaited_results.push_back(r);
  endtask

  // Update the mirrored list for one request and predict its results.
  task automatic list_apply(input in_item_t rq);
    int                p;
    int                i;
    int                hits;
    int                k;
    logic [WORD_W-1:0] word;
    p = int'(rq.position);
    case (rq.req_type)
      REQ_INSERT: begin
        if (list_len >= CAPACITY) begin
          push_result(ST_FULL, 0, '0, 1'b1);
        end else if (p < 1 || p > list_len + 1) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (i = list_len; i > p - 1; i--) list_words[i] = list_words[i - 1];
          list_words[p - 1] = rq.value;
          list_len++;
          push_result(ST_OK, p, rq.value, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (p < 1 || p > list_len) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          word = list_words[p - 1];
          for (i = p; i < list_len; i++) list_words[i - 1] = list_words[i];
          list_len--;
          push_result(ST_OK, p, word, 1'b1);
        end
      end
      REQ_SEARCH: begin
        hits = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == rq.value) hits++;
        end
        if (hits == 0) push_result(ST_NOTFOUND, 0, '0, 1'b1);
        k = 0;
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == rq.value) begin
            k++;
            push_result(ST_OK, i + 1, rq.value, k == hits);
          end
        end
      end
      REQ_READ: begin
        if (p < 1 || p > list_len) push_result(ST_BADPOS, 0, '0, 1'b1);
        else push_result(ST_OK, p, list_words[p - 1], 1'b1);
      end
      REQ_CLEAR: begin
        list_len = 0;
        push_result(ST_OK, 0, '0, 1'b1);
      end
      default: begin
        push_result(ST_OK, 0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      $error("result with no request pending: status %0d, found_position %0d",
             got.status, got.found_position);
      fail_count++;
    end else begin
      want = awaited_results.pop_front();
      check_field("status", longint'(want.status), longint'(got.status));
      check_field("found_position", longint'(want.found_position),
                  longint'(got.found_position));
      check_field("read_value", longint'($signed(want.read_value)),
                  longint'($signed(got.read_value)));
      check_field("list_length", longint'(want.list_length), longint'(got.list_length));
      check_field("last", longint'(want.last), longint'(got.last));
    end
  endtask

  // Retire results before taking a new request: a result leaving at the
  // same edge always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst_n) begin
      list_len = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) list_apply(in_data);
    end
    pending_cnt = awaited_results.size();
    tracked_len = LEN_W'(list_len);
  end

endmodule

@@ bench/sequential_list_engine_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sequential list engine: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on sle_pkg,
// sequential_list_engine and sle_list_checker.

module sequential_list_engine_tb;
  import sle_pkg::*;

  localparam int CAPACITY = 64;
  // Request codes above clear are ignored by the block; this is the first of them.
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam int FILL_ITEMS   = 95;   // insert-heavy: drive the list to full
  localparam int MIX_ITEMS    = 40;   // all operations, lengths wander
  localparam int QUIET_ITEMS  = 25;   // final stretch with no idling on either side
  // Longest correct silence: sender gap + full-length insert + receiver stall;
  // the limit leaves a wide margin over it.
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = CAPACITY + 16;

  bit               clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;

  int               fail_count;
  int               pending_cnt;
  logic [LEN_W-1:0] tracked_len;
  bit               quiet_tail;
  int               idle_cycles;
  int               stall_left;
  int               item_no;

  sequential_list_engine #(.CAPACITY(CAPACITY)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sle_list_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt),
    .tracked_len (tracked_len)
  );

  // 10 ns clock; first rising edge at 5 ns, so nothing fires at time zero.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: alternate random stall bursts with free-running
  // stretches of random length; drop stalls entirely in the tail.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (quiet_tail) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!out_stall && $urandom_range(0, 2) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(0, 19);
      end
    end
  end

  // Watchdog: count cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one request at a falling edge, optionally after an idle burst,
  // and hold it until a rising edge accepts it. Returns at the next falling
  // edge so the following request can go out without dropping valid.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] pos,
                          input logic [WORD_W-1:0] word);
    in_item_t item;
    int       gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.req_type = kind;
    item.position = pos;
    item.value    = word;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Favor the extremes and a few repeated words so searches hit several times.
  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position for the current length; now and then one just
  // past the end, zero, or anything the 7-bit field can carry.
  function automatic logic [LEN_W-1:0] pick_position(input logic [REQ_W-1:0] kind,
                                                     input int len);
    int top_ok;
    top_ok = (kind == REQ_INSERT) ? len + 1 : len;
    if (top_ok < 1 || $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return LEN_W'(top_ok + 1);
        default: return LEN_W'($urandom_range(0, 127));
      endcase
    end
    return LEN_W'($urandom_range(1, top_ok));
  endfunction

  task automatic send_random(input bit fill_phase);
    int               roll;
    logic [REQ_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (fill_phase) begin
      if (roll < 88)      kind = REQ_INSERT;
      else if (roll < 92) kind = REQ_SEARCH;
      else if (roll < 96) kind = REQ_READ;
      else                kind = REQ_DELETE;
    end else begin
      if (roll < 25)      kind = REQ_INSERT;
      else if (roll < 50) kind = REQ_DELETE;
      else if (roll < 70) kind = REQ_SEARCH;
      else if (roll < 90) kind = REQ_READ;
      else if (roll < 94) kind = REQ_CLEAR;
      else                kind = REQ_W'(REQ_SPARE_FIRST + $urandom_range(0, 2));
    end
    // tracked_len is settled by the falling edge, after the last acceptance.
    send_req(kind, pick_position(kind, int'(tracked_len)), pick_value());
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: every position is out of range, search finds nothing.
    send_req(REQ_READ,   7'd1, 32'h0);
    send_req(REQ_DELETE, 7'd1, 32'h0);
    send_req(REQ_SEARCH, 7'd0, 32'h0);
    send_req(REQ_INSERT, 7'd2, 32'h1234_5678);
    send_req(REQ_INSERT, 7'd0, 32'h1234_5678);
    // Build -1, MIN, MAX, MAX: insert first, append, front, middle.
    send_req(REQ_INSERT, 7'd1, 32'h8000_0000);
    send_req(REQ_INSERT, 7'd2, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, 7'd1, 32'hFFFF_FFFF);
    send_req(REQ_INSERT, 7'd3, 32'h7FFF_FFFF);
    // Search with two matches, then with none.
    send_req(REQ_SEARCH, 7'd0, 32'h7FFF_FFFF);
    send_req(REQ_SEARCH, 7'd0, 32'h0);
    // Read the last entry, one past it, and the top of the position field.
    send_req(REQ_READ,   7'd4, 32'h0);
    send_req(REQ_READ,   7'd5, 32'h0);
    send_req(REQ_READ,   7'd127, 32'hFFFF_FFFF);
    // Delete from the middle, then the tail, then position zero.
    send_req(REQ_DELETE, 7'd2, 32'h0);
    send_req(REQ_DELETE, 7'd3, 32'h0);
    send_req(REQ_DELETE, 7'd0, 32'h0);
    // Ignored request codes with every position bit set.
    send_req(REQ_SPARE_FIRST,              7'd127, 32'hFFFF_FFFF);
    send_req(REQ_W'(REQ_SPARE_FIRST + 1),  7'd127, 32'h5555_AAAA);
    send_req(REQ_W'(REQ_SPARE_FIRST + 2),  7'd127, 32'hAAAA_5555);
    send_req(REQ_INSERT, 7'd127, 32'h0);
    // Clear, confirm the list is empty, then a single-match search.
    send_req(REQ_CLEAR,  7'd127, 32'hFFFF_FFFF);
    send_req(REQ_READ,   7'd1, 32'h0);
    send_req(REQ_INSERT, 7'd1, 32'h0);
    send_req(REQ_SEARCH, 7'd0, 32'h0);

    for (item_no = 0; item_no < FILL_ITEMS; item_no++) send_random(1'b1);
    for (item_no = 0; item_no < MIX_ITEMS + QUIET_ITEMS; item_no++) begin
      if (item_no == MIX_ITEMS) quiet_tail = 1'b1;
      send_random(1'b0);
    end
    in_valid <= 1'b0;

    // Drain: wait out every predicted result, then give stray results time to show.
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
